// ===== rtl/core/pbc_pkg.sv =====
// Package for the parabolic blending curve evaluator: widths, request and
// status codes, sequencer states, the multiplier control bundle and helpers.
// No dependencies.
package pbc_pkg;

   // Default parameter values
   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 32;

   // Fixed field widths
   localparam int KNOT_W = 17;
   localparam int IDX_W  = 6;
   localparam int OUT_W  = 32;
   localparam int WFRAC  = 28;

   // Multiplier and accumulator widths
   localparam int MAG_W  = 64;
   localparam int HALF_W = 32;
   localparam int ACC_W  = 128;

   // Divider widths and polynomial term width
   localparam int DVD_W  = 64;
   localparam int DVS_W  = 36;
   localparam int POLY_W = 36;

   // Request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_EVAL = 2'd1;
   localparam logic [1:0] REQ_EDIT = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_DOMAIN  = 2'd1;
   localparam logic [1:0] STAT_NUMERIC = 2'd2;

   // Control bundle for the shared multiply-accumulate unit
   typedef struct packed {
      logic start;
      logic clear;
      logic neg;
   } pbc_mac_ctl_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EDIT_RD,
      ST_EDIT_WR,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SPAN,
      ST_KN_RD,
      ST_KN_CAP,
      ST_POLY,
      ST_DEN_CHK,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CO_RD,
      ST_MAC_GO,
      ST_MAC_WAIT,
      ST_LG_RND,
      ST_T_GO,
      ST_T_WAIT,
      ST_BL_GO,
      ST_BL_WAIT,
      ST_BL_RND,
      ST_DONE
   } pbc_state_type;

   // Signed difference of two unsigned parameters
   function automatic logic signed [KNOT_W:0] kdiff(input logic [KNOT_W-1:0] a,
                                                    input logic [KNOT_W-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   // Magnitude of a signed 64-bit value
   function automatic logic [MAG_W-1:0] mag64(input logic signed [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

endpackage

// ===== rtl/core/pbc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pbc_pkg.
module pbc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pbc_pkg::DVD_W-1:0]  dividend,
   input  logic [pbc_pkg::DVS_W-1:0]  divisor,
   output logic                       busy,
   output logic [pbc_pkg::DVD_W-1:0]  quotient
);
   import pbc_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             run_ff, run_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // One shift-subtract step
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DVD_W);
         rem_in = '0;
         dvs_in = divisor;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = run_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/pbc_mac.sv =====
// Shared multiply-accumulate unit: 64x64 magnitude product as four 32x32
// partial products, signed accumulation into a 128-bit register.
// Depends on pbc_pkg.
module pbc_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  pbc_pkg::pbc_mac_ctl_type          ctl,
   input  logic [pbc_pkg::MAG_W-1:0]         a_mag,
   input  logic [pbc_pkg::MAG_W-1:0]         b_mag,
   output logic                              busy,
   output logic signed [pbc_pkg::ACC_W-1:0]  acc
);
   import pbc_pkg::*;

   logic                     run_ff, run_in;
   logic [1:0]               step_ff, step_in;
   logic [MAG_W-1:0]         a_ff, a_in;
   logic [MAG_W-1:0]         b_ff, b_in;
   logic                     neg_ff, neg_in;
   logic [2*HALF_W-1:0]      pp_ff, pp_in;
   logic [1:0]               sh_ff, sh_in;
   logic                     pp_vld_ff, pp_vld_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [HALF_W-1:0]        a_part;
   logic [HALF_W-1:0]        b_part;
   logic signed [ACC_W-1:0]  term;

   // Partial product stage, then shifted add stage
   always_comb begin
      a_part    = step_ff[0] ? a_ff[MAG_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_part    = step_ff[1] ? b_ff[MAG_W-1:HALF_W] : b_ff[HALF_W-1:0];
      term      = $signed(ACC_W'(pp_ff) << {sh_ff, 5'b0});
      run_in    = run_ff;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      pp_in     = pp_ff;
      sh_in     = sh_ff;
      pp_vld_in = 1'b0;
      acc_in    = acc_ff;
      if (ctl.start) begin
         run_in  = 1'b1;
         step_in = '0;
         a_in    = a_mag;
         b_in    = b_mag;
         neg_in  = ctl.neg;
      end else if (run_ff) begin
         pp_in     = a_part * b_part;
         sh_in     = 2'(step_ff[0]) + 2'(step_ff[1]);
         pp_vld_in = 1'b1;
         step_in   = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pp_vld_ff) begin
         acc_in = neg_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         pp_vld_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         pp_vld_ff <= pp_vld_in;
      end
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
   end

   assign busy = run_ff | pp_vld_ff;
   assign acc  = acc_ff;

endmodule

// ===== rtl/core/parabolic_blend_curve_eval_top.sv =====
// Top level of the parabolic blending curve evaluator: point stores, span
// search and the sequencer that drives the shared divider and multiplier.
// Depends on pbc_pkg, pbc_div and pbc_mac.
//
// A transaction is taken when start is high and busy is low; busy stays high
// until its single result has been shown for one cycle under rsp_strobe. The
// receiver cannot stall, so rsp_* must be captured in the strobe cycle. An
// evaluate runs a span search over knots 0..n, then per quadratic interpolant
// a knot fetch, products, three divisions, twelve multiply passes and
// rounding, and for inner spans a second interpolant and a blend (one more
// division and eight multiply passes).
module parabolic_blend_curve_eval_top #(
   parameter int MAX_POINTS = pbc_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pbc_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [pbc_pkg::IDX_W-1:0]         req_point_index,
   input  logic signed [pbc_pkg::OUT_W-1:0]  req_coord_x,
   input  logic signed [pbc_pkg::OUT_W-1:0]  req_coord_y,
   input  logic signed [pbc_pkg::OUT_W-1:0]  req_coord_z,
   input  logic signed [pbc_pkg::OUT_W-1:0]  req_coord_w,
   input  logic [pbc_pkg::KNOT_W-1:0]        req_knot_value,
   input  logic [pbc_pkg::KNOT_W-1:0]        req_eval_u,
   output logic                              rsp_strobe,
   output logic signed [pbc_pkg::OUT_W-1:0]  rsp_out_x,
   output logic signed [pbc_pkg::OUT_W-1:0]  rsp_out_y,
   output logic signed [pbc_pkg::OUT_W-1:0]  rsp_out_z,
   output logic signed [pbc_pkg::OUT_W-1:0]  rsp_out_w,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbc_pkg::IDX_W-1:0]         csr_last_point_index
);
   import pbc_pkg::*;

   localparam int AW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LAW      = IDX_W + 1;
   localparam int OUT_BITS = (COORD_BITS < OUT_W) ? COORD_BITS : OUT_W;
   localparam int SUM_W    = 50;

   // Saturate a sum to the stored coordinate width
   function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      logic [COORD_BITS-1:0]   r;
      hi = $signed((SUM_W'(1) << (COORD_BITS - 1)) - SUM_W'(1));
      lo = ~hi;
      if (v > hi) begin
         r = hi[COORD_BITS-1:0];
      end else if (v < lo) begin
         r = lo[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // Sequencer registers
   pbc_state_type            state_ff, state_in;
   logic [IDX_W-1:0]         n_ff, n_in;
   logic [IDX_W-1:0]         pi_ff, pi_in;
   logic [KNOT_W-1:0]        u_ff, u_in;
   logic [OUT_W-1:0]         din_ff [4];
   logic [OUT_W-1:0]         din_in [4];
   logic [IDX_W:0]           k_ff, k_in;
   logic [KNOT_W-1:0]        kprev_ff, kprev_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic                     pass_ff, pass_in;
   logic                     blend_ff, blend_in;
   logic [1:0]               m_ff, m_in;
   logic [1:0]               c_ff, c_in;
   logic [2:0]               step_ff, step_in;
   logic [KNOT_W-1:0]        kn_ff [3];
   logic [KNOT_W-1:0]        kn_in [3];
   logic signed [POLY_W-1:0] poly_ff [6];
   logic signed [POLY_W-1:0] poly_in [6];
   logic [MAG_W-1:0]         wmag_ff [3];
   logic [MAG_W-1:0]         wmag_in [3];
   logic                     wneg_ff [3];
   logic                     wneg_in [3];
   logic [OUT_W-1:0]         p0_ff [4];
   logic [OUT_W-1:0]         p0_in [4];
   logic [OUT_W-1:0]         p1_ff [4];
   logic [OUT_W-1:0]         p1_in [4];
   logic [OUT_W-1:0]         res_ff [4];
   logic [OUT_W-1:0]         res_in [4];
   logic [1:0]               status_ff, status_in;
   logic [WFRAC:0]           t_ff, t_in;

   // Point stores
   logic [COORD_BITS-1:0]    coord_mem [4][MAX_POINTS];
   logic [KNOT_W-1:0]        knot_mem [MAX_POINTS];
   logic [COORD_BITS-1:0]    coord_q_ff [4];
   logic [KNOT_W-1:0]        knot_q_ff;
   logic [AW-1:0]            knot_raddr;
   logic [AW-1:0]            coord_raddr;
   logic [AW-1:0]            coord_waddr;
   logic [COORD_BITS-1:0]    coord_wdata [4];
   logic                     coord_we;
   logic                     knot_we;

   // Datapath helpers
   logic                     accept;
   logic                     pi_ok;
   logic [OUT_W-1:0]         req_coord [4];
   logic [AW-1:0]            lag_addr;
   logic signed [KNOT_W:0]   px, py;
   logic signed [POLY_W-1:0] poly_prod;
   logic signed [POLY_W-1:0] num_sel, den_sel;
   logic [POLY_W-1:0]        an, ad;
   logic [2:0]               num_ix;
   logic [KNOT_W-1:0]        ud;
   logic [OUT_W-1:0]         psel;
   logic [WFRAC:0]           one_minus_t;
   logic signed [ACC_W-1:0]  rnd_sum, rnd_sh;
   logic                     rnd_fit;
   logic [OUT_W-1:0]         rnd_val;

   // Shared units
   logic                     div_start, div_busy;
   logic [DVD_W-1:0]         div_dividend, div_quotient;
   logic [DVS_W-1:0]         div_divisor;
   pbc_mac_ctl_type          mac_ctl;
   logic                     mac_busy;
   logic [MAG_W-1:0]         mac_a, mac_b;
   logic signed [ACC_W-1:0]  mac_acc;

   pbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   pbc_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a_mag (mac_a),
      .b_mag (mac_b),
      .busy  (mac_busy),
      .acc   (mac_acc)
   );

   assign accept       = start & ~busy;
   assign pi_ok        = (32'(req_point_index) < MAX_POINTS);
   assign req_coord[0] = req_coord_x;
   assign req_coord[1] = req_coord_y;
   assign req_coord[2] = req_coord_z;
   assign req_coord[3] = req_coord_w;
   assign lag_addr     = AW'(LAW'(j_ff) + LAW'(m_ff));

   // Polynomial factor selection for denominators and numerators
   always_comb begin
      case (step_ff)
         3'd0: begin
            px = kdiff(kn_ff[0], kn_ff[1]);
            py = kdiff(kn_ff[0], kn_ff[2]);
         end
         3'd1: begin
            px = kdiff(kn_ff[1], kn_ff[0]);
            py = kdiff(kn_ff[1], kn_ff[2]);
         end
         3'd2: begin
            px = kdiff(kn_ff[2], kn_ff[0]);
            py = kdiff(kn_ff[2], kn_ff[1]);
         end
         3'd3: begin
            px = kdiff(u_ff, kn_ff[1]);
            py = kdiff(u_ff, kn_ff[2]);
         end
         3'd4: begin
            px = kdiff(u_ff, kn_ff[0]);
            py = kdiff(u_ff, kn_ff[2]);
         end
         3'd5: begin
            px = kdiff(u_ff, kn_ff[0]);
            py = kdiff(u_ff, kn_ff[1]);
         end
         default: begin
            px = '0;
            py = '0;
         end
      endcase
      poly_prod = px * py;
   end

   // Weight division operands
   assign num_ix  = 3'(m_ff) + 3'd3;
   assign num_sel = poly_ff[num_ix];
   assign den_sel = poly_ff[3'(m_ff)];
   assign an      = num_sel[POLY_W-1] ? POLY_W'(-num_sel) : POLY_W'(num_sel);
   assign ad      = den_sel[POLY_W-1] ? POLY_W'(-den_sel) : POLY_W'(den_sel);
   assign ud      = u_ff - kn_ff[0];

   // Blend operands
   assign psel        = (m_ff == 2'd0) ? p0_ff[c_ff] : p1_ff[c_ff];
   assign one_minus_t = ((WFRAC + 1)'(1) << WFRAC) - t_ff;

   // Round half up to Q16.16 and range check
   assign rnd_sum = mac_acc + $signed(ACC_W'(1) << (WFRAC - 1));
   assign rnd_sh  = rnd_sum >>> WFRAC;
   assign rnd_fit = (ACC_W'($signed(rnd_sh[OUT_BITS-1:0])) == rnd_sh);
   assign rnd_val = OUT_W'($signed(rnd_sh[OUT_BITS-1:0]));

   // Next state and datapath control
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      pi_in     = pi_ff;
      u_in      = u_ff;
      k_in      = k_ff;
      kprev_in  = kprev_ff;
      found_in  = found_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      pass_in   = pass_ff;
      blend_in  = blend_ff;
      m_in      = m_ff;
      c_in      = c_ff;
      step_in   = step_ff;
      status_in = status_ff;
      t_in      = t_ff;
      for (int i = 0; i < 4; i++) begin
         din_in[i] = din_ff[i];
         p0_in[i]  = p0_ff[i];
         p1_in[i]  = p1_ff[i];
         res_in[i] = res_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         kn_in[i]   = kn_ff[i];
         wmag_in[i] = wmag_ff[i];
         wneg_in[i] = wneg_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         poly_in[i] = poly_ff[i];
      end

      div_start    = 1'b0;
      div_dividend = (DVD_W'(an) << (WFRAC + 1)) + DVD_W'(ad);
      div_divisor  = {ad[DVS_W-2:0], 1'b0};
      mac_ctl      = '0;
      mac_a        = wmag_ff[m_ff];
      mac_b        = mag64(MAG_W'($signed(coord_q_ff[c_ff])));
      knot_raddr   = AW'(k_ff);
      coord_raddr  = lag_addr;
      coord_waddr  = AW'(pi_ff);
      coord_we     = 1'b0;
      knot_we      = 1'b0;
      for (int i = 0; i < 4; i++) begin
         coord_wdata[i] = sat_coord(SUM_W'($signed(coord_q_ff[i]))
                                    + SUM_W'($signed(din_ff[i])));
      end

      // Configuration register, clamped to the stored range
      if (csr_valid) begin
         if (csr_last_point_index < IDX_W'(2)) begin
            n_in = IDX_W'(2);
         end else if (32'(csr_last_point_index) > MAX_POINTS - 1) begin
            n_in = IDX_W'(MAX_POINTS - 1);
         end else begin
            n_in = csr_last_point_index;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               pi_in     = req_point_index;
               u_in      = req_eval_u;
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = '0;
                  din_in[i] = req_coord[i];
               end
               state_in = ST_DONE;
               if (req_type == REQ_LOAD) begin
                  coord_waddr = AW'(req_point_index);
                  coord_we    = pi_ok;
                  knot_we     = pi_ok;
                  for (int i = 0; i < 4; i++) begin
                     coord_wdata[i] = sat_coord(SUM_W'($signed(req_coord[i])));
                  end
               end else if (req_type == REQ_EDIT) begin
                  if (pi_ok) begin
                     state_in = ST_EDIT_RD;
                  end
               end else if (req_type == REQ_EVAL) begin
                  k_in     = '0;
                  found_in = 1'b0;
                  state_in = ST_SRCH_RD;
               end
            end
         end
         // Read-modify-write of one point
         ST_EDIT_RD: begin
            coord_raddr = AW'(pi_ff);
            state_in    = ST_EDIT_WR;
         end
         ST_EDIT_WR: begin
            coord_we = 1'b1;
            state_in = ST_DONE;
         end
         // Span search over knots 0..n
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            kprev_in = knot_q_ff;
            if ((k_ff != '0) && !found_ff && (kprev_ff <= u_ff) && (u_ff < knot_q_ff)) begin
               found_in = 1'b1;
               idx_in   = IDX_W'(k_ff - LAW'(1));
            end
            if (k_ff == LAW'(n_ff)) begin
               if (u_ff == knot_q_ff) begin
                  found_in = 1'b1;
                  idx_in   = n_ff - IDX_W'(1);
               end
               state_in = ST_SPAN;
            end else begin
               k_in     = k_ff + LAW'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SPAN: begin
            pass_in = 1'b0;
            m_in    = '0;
            if (!found_ff) begin
               status_in = STAT_DOMAIN;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_KN_RD;
               if (idx_ff == '0) begin
                  j_in     = '0;
                  blend_in = 1'b0;
               end else if (idx_ff == n_ff - IDX_W'(1)) begin
                  j_in     = idx_ff - IDX_W'(1);
                  blend_in = 1'b0;
               end else begin
                  j_in     = idx_ff - IDX_W'(1);
                  blend_in = 1'b1;
               end
            end
         end
         // Fetch the three knots of the interpolant
         ST_KN_RD: begin
            knot_raddr = lag_addr;
            state_in   = ST_KN_CAP;
         end
         ST_KN_CAP: begin
            kn_in[m_ff] = knot_q_ff;
            if (m_ff == 2'd2) begin
               m_in     = '0;
               step_in  = '0;
               state_in = ST_POLY;
            end else begin
               m_in     = m_ff + 2'd1;
               state_in = ST_KN_RD;
            end
         end
         // Denominators then numerators, one product per cycle
         ST_POLY: begin
            poly_in[step_ff] = poly_prod;
            if (step_ff == 3'd5) begin
               state_in = ST_DEN_CHK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DEN_CHK: begin
            m_in = '0;
            if ((poly_ff[0] == '0) || (poly_ff[1] == '0) || (poly_ff[2] == '0)) begin
               status_in = STAT_NUMERIC;
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = '0;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         // Lagrange weights, rounded to 28 fraction bits
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!div_busy) begin
               wmag_in[m_ff] = div_quotient;
               wneg_in[m_ff] = num_sel[POLY_W-1] ^ den_sel[POLY_W-1];
               if (m_ff == 2'd2) begin
                  m_in     = '0;
                  c_in     = '0;
                  state_in = ST_CO_RD;
               end else begin
                  m_in     = m_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         // Weighted sum of three points, one coordinate at a time
         ST_CO_RD: begin
            state_in = ST_MAC_GO;
         end
         ST_MAC_GO: begin
            mac_ctl.start = 1'b1;
            mac_ctl.clear = (m_ff == 2'd0);
            mac_ctl.neg   = wneg_ff[m_ff] ^ coord_q_ff[c_ff][COORD_BITS-1];
            state_in      = ST_MAC_WAIT;
         end
         ST_MAC_WAIT: begin
            if (!mac_busy) begin
               if (m_ff == 2'd2) begin
                  state_in = ST_LG_RND;
               end else begin
                  m_in     = m_ff + 2'd1;
                  state_in = ST_CO_RD;
               end
            end
         end
         ST_LG_RND: begin
            if (!rnd_fit) begin
               status_in = STAT_NUMERIC;
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = '0;
               end
               state_in = ST_DONE;
            end else begin
               if (pass_ff) begin
                  p1_in[c_ff] = rnd_val;
               end else begin
                  p0_in[c_ff] = rnd_val;
                  if (!blend_ff) begin
                     res_in[c_ff] = rnd_val;
                  end
               end
               m_in = '0;
               if (c_ff == 2'd3) begin
                  if (!blend_ff) begin
                     state_in = ST_DONE;
                  end else if (!pass_ff) begin
                     pass_in  = 1'b1;
                     j_in     = idx_ff;
                     state_in = ST_KN_RD;
                  end else begin
                     state_in = ST_T_GO;
                  end
               end else begin
                  c_in     = c_ff + 2'd1;
                  state_in = ST_CO_RD;
               end
            end
         end
         // Local parameter t of the inner span
         ST_T_GO: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(ud) << WFRAC;
            div_divisor  = DVS_W'(kn_ff[1] - kn_ff[0]);
            state_in     = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            if (!div_busy) begin
               t_in     = div_quotient[WFRAC:0];
               c_in     = '0;
               m_in     = '0;
               state_in = ST_BL_GO;
            end
         end
         // Linear blend of the two interpolants
         ST_BL_GO: begin
            mac_ctl.start = 1'b1;
            mac_ctl.clear = (m_ff == 2'd0);
            mac_ctl.neg   = psel[OUT_W-1];
            mac_a         = mag64(MAG_W'($signed(psel)));
            mac_b         = (m_ff == 2'd0) ? MAG_W'(one_minus_t) : MAG_W'(t_ff);
            state_in      = ST_BL_WAIT;
         end
         ST_BL_WAIT: begin
            if (!mac_busy) begin
               if (m_ff == 2'd1) begin
                  state_in = ST_BL_RND;
               end else begin
                  m_in     = 2'd1;
                  state_in = ST_BL_GO;
               end
            end
         end
         ST_BL_RND: begin
            m_in = '0;
            if (!rnd_fit) begin
               status_in = STAT_NUMERIC;
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = '0;
               end
               state_in = ST_DONE;
            end else begin
               res_in[c_ff] = rnd_val;
               if (c_ff == 2'd3) begin
                  state_in = ST_DONE;
               end else begin
                  c_in     = c_ff + 2'd1;
                  state_in = ST_BL_GO;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= IDX_W'(2);
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pi_ff     <= pi_in;
      u_ff      <= u_in;
      k_ff      <= k_in;
      kprev_ff  <= kprev_in;
      found_ff  <= found_in;
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      pass_ff   <= pass_in;
      blend_ff  <= blend_in;
      m_ff      <= m_in;
      c_ff      <= c_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      t_ff      <= t_in;
      for (int i = 0; i < 4; i++) begin
         din_ff[i] <= din_in[i];
         p0_ff[i]  <= p0_in[i];
         p1_ff[i]  <= p1_in[i];
         res_ff[i] <= res_in[i];
      end
      for (int i = 0; i < 3; i++) begin
         kn_ff[i]   <= kn_in[i];
         wmag_ff[i] <= wmag_in[i];
         wneg_ff[i] <= wneg_in[i];
      end
      for (int i = 0; i < 6; i++) begin
         poly_ff[i] <= poly_in[i];
      end
   end

   // Point stores, one write and one registered read each
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (coord_we) begin
            coord_mem[i][coord_waddr] <= coord_wdata[i];
         end
         coord_q_ff[i] <= coord_mem[i][coord_raddr];
      end
      if (knot_we) begin
         knot_mem[coord_waddr] <= req_knot_value;
      end
      knot_q_ff <= knot_mem[knot_raddr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_out_x  = res_ff[0];
   assign rsp_out_y  = res_ff[1];
   assign rsp_out_z  = res_ff[2];
   assign rsp_out_w  = res_ff[3];
   assign rsp_status = status_ff;
   assign csr_ready  = 1'b1;

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |->
      (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && rsp_out_w == '0))
      else $error("nonzero result with error status");

   a_mac_idle: assert property (@(posedge clock) disable iff (reset)
      mac_ctl.start |-> !mac_busy)
      else $error("multiplier started while busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

// ===== sim/testbench.sv =====
// Testbench for parabolic_blend_curve_eval_top: loads, edits and evaluations
// are checked one by one against a predictor kept in a small scoreboard class.
// Depends on pbc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
   import pbc_pkg::*;

   // Request code the block does not define
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic [1:0]         kind;
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] crd[4];
      logic [KNOT_W-1:0]  knot;
      logic [KNOT_W-1:0]  u;
   } curve_req_type;

   typedef struct {
      logic signed [31:0] val[4];
      logic [1:0]         st;
   } curve_rsp_type;

   // Predicts each response and holds the ones not yet seen
   class curve_scoreboard;
      logic signed [31:0]  pts[4][64];
      logic [KNOT_W-1:0]   knots[64];
      int                  last_idx;
      longint signed       lg[4];
      curve_rsp_type       awaited[$];
      int                  errors;

      function new();
         last_idx = 2;
         errors   = 0;
      endfunction

      function void set_last(logic [IDX_W-1:0] v);
         last_idx = (v < 2) ? 2 : int'(v);
      endfunction

      function logic signed [127:0] mul(longint signed a, longint signed b);
         logic signed [127:0] x, y;
         x = a;
         y = b;
         return x * y;
      endfunction

      // Lagrange weight with 28 fraction bits, magnitude rounded half away
      function longint signed weight(longint signed num, longint signed den);
         longint unsigned an, ad, q, rm, f;
         longint signed   w;
         an = (num < 0) ? -num : num;
         ad = (den < 0) ? -den : den;
         q  = an / ad;
         rm = an % ad;
         f  = ((rm << (WFRAC + 1)) + ad) / (ad << 1);
         w  = (q << WFRAC) + f;
         return ((num < 0) != (den < 0)) ? -w : w;
      endfunction

      // Round half up to Q16.16, fail when outside 32 signed bits
      function bit round_q(logic signed [127:0] a, output longint signed res);
         logic signed [127:0] s;
         s = (a + 128'sd134217728) >>> WFRAC;
         res = longint'(s);
         return !(s > 128'sh7FFFFFFF || s < -128'sh80000000);
      endfunction

      // Quadratic through points j..j+2, result left in lg
      function bit interp(int j, longint signed u);
         longint signed       ka, kb, kc, da, db, dc, wa, wb, wc, r;
         logic signed [127:0] acc;
         ka = longint'(knots[j]);
         kb = longint'(knots[j+1]);
         kc = longint'(knots[j+2]);
         da = (ka - kb) * (ka - kc);
         db = (kb - ka) * (kb - kc);
         dc = (kc - ka) * (kc - kb);
         if (da == 0 || db == 0 || dc == 0) return 0;
         wa = weight((u - kb) * (u - kc), da);
         wb = weight((u - ka) * (u - kc), db);
         wc = weight((u - ka) * (u - kb), dc);
         for (int c = 0; c < 4; c++) begin
            acc = mul(wa, pts[c][j]) + mul(wb, pts[c][j+1]) + mul(wc, pts[c][j+2]);
            if (!round_q(acc, r)) return 0;
            lg[c] = r;
         end
         return 1;
      endfunction

      function logic [1:0] evaluate(longint signed u, ref curve_rsp_type rsp);
         int                  n, span;
         longint signed       p0[4], k0, k1, t, r;
         logic signed [127:0] acc;
         n    = last_idx;
         span = -1;
         for (int i = 0; i < n; i++) begin
            if (u >= longint'(knots[i]) && u < longint'(knots[i+1])) begin
               span = i;
               break;
            end
         end
         if (u == longint'(knots[n])) span = n - 1;
         if (span < 0) return STAT_DOMAIN;
         // end spans use a single quadratic
         if (span == 0 || span == n - 1) begin
            if (!interp((span == 0) ? 0 : span - 1, u)) return STAT_NUMERIC;
            for (int c = 0; c < 4; c++) rsp.val[c] = lg[c][31:0];
            return STAT_OK;
         end
         if (!interp(span - 1, u)) return STAT_NUMERIC;
         p0 = lg;
         if (!interp(span, u)) return STAT_NUMERIC;
         k0 = longint'(knots[span]);
         k1 = longint'(knots[span+1]);
         t  = ((u - k0) << WFRAC) / (k1 - k0);
         for (int c = 0; c < 4; c++) begin
            acc = mul(p0[c], (64'sd1 << WFRAC) - t) + mul(lg[c], t);
            if (!round_q(acc, r)) return STAT_NUMERIC;
            rsp.val[c] = r[31:0];
         end
         return STAT_OK;
      endfunction

      function void note_request(curve_req_type rq);
         curve_rsp_type rsp;
         longint signed sum;
         for (int c = 0; c < 4; c++) rsp.val[c] = '0;
         rsp.st = STAT_OK;
         case (rq.kind)
            REQ_LOAD: begin
               for (int c = 0; c < 4; c++) pts[c][rq.idx] = rq.crd[c];
               knots[rq.idx] = rq.knot;
            end
            REQ_EDIT: begin
               for (int c = 0; c < 4; c++) begin
                  sum = longint'(pts[c][rq.idx]) + longint'(rq.crd[c]);
                  if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
                  if (sum < -64'sh80000000) sum = -64'sh80000000;
                  pts[c][rq.idx] = sum[31:0];
               end
            end
            REQ_EVAL: begin
               rsp.st = evaluate(longint'(rq.u), rsp);
               if (rsp.st != STAT_OK)
                  for (int c = 0; c < 4; c++) rsp.val[c] = '0;
            end
            default: ;
         endcase
         awaited.push_back(rsp);
      endfunction

      function void check_result(curve_rsp_type got);
         curve_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with none pending: status %0d", $time, got.st);
            errors++;
            return;
         end
         want = awaited.pop_front();
         for (int c = 0; c < 4; c++) begin
            if (got.val[c] !== want.val[c]) begin
               $display("%0t: coord %0d expected %h actual %h", $time, c,
                        want.val[c], got.val[c]);
               errors++;
            end
         end
         if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = '0;
   logic [IDX_W-1:0]   req_point_index = '0;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0, req_coord_w = '0;
   logic [KNOT_W-1:0]  req_knot_value = '0, req_eval_u = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_last_point_index = '0;

   parabolic_blend_curve_eval_top dut (
      .clock, .reset, .start, .busy,
      .req_type, .req_point_index,
      .req_coord_x, .req_coord_y, .req_coord_z, .req_coord_w,
      .req_knot_value, .req_eval_u,
      .rsp_strobe, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_w, .rsp_status,
      .csr_valid, .csr_ready, .csr_last_point_index
   );

   curve_scoreboard sb = new();

   // Generator state
   bit                 written[64];
   logic [KNOT_W-1:0]  gen_knot[64];
   int                 cur_last = 2;
   int                 pending_gap = 0;
   bit                 no_gaps = 0;
   int                 sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Response monitor
   always @(posedge clock) begin
      curve_rsp_type got;
      if (rsp_strobe) begin
         got.val[0] = rsp_out_x;
         got.val[1] = rsp_out_y;
         got.val[2] = rsp_out_z;
         got.val[3] = rsp_out_w;
         got.st     = rsp_status;
         sb.check_result(got);
      end
   end

   function int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 120);
   endfunction

   function logic signed [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
      if (r < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sh0;
         default: return -32'sh1;
      endcase
   endfunction

   // Drive one transaction and wait for it to be taken
   task automatic send(curve_req_type rq);
      if (pending_gap > 0) repeat (pending_gap) @(posedge clock);
      start           <= 1'b1;
      req_type        <= rq.kind;
      req_point_index <= rq.idx;
      req_coord_x     <= rq.crd[0];
      req_coord_y     <= rq.crd[1];
      req_coord_z     <= rq.crd[2];
      req_coord_w     <= rq.crd[3];
      req_knot_value  <= rq.knot;
      req_eval_u      <= rq.u;
      do @(posedge clock); while (busy);
      sb.note_request(rq);
      sent++;
      if (rq.kind == REQ_LOAD) begin
         written[rq.idx]  = 1;
         gen_knot[rq.idx] = rq.knot;
      end
      pending_gap = pick_gap();
      if (pending_gap > 0) start <= 1'b0;
   endtask

   task automatic wait_drained();
      if (pending_gap == 0) start <= 1'b0;
      pending_gap = 1;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_last(logic [IDX_W-1:0] v);
      wait_drained();
      csr_valid            <= 1'b1;
      csr_last_point_index <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_last(v);
      cur_last = (v < 2) ? 2 : int'(v);
   endtask

   function curve_req_type mk(logic [1:0] kind, int idx, logic signed [31:0] cv,
                              int knot, int u);
      curve_req_type rq;
      rq.kind = kind;
      rq.idx  = IDX_W'(idx);
      for (int c = 0; c < 4; c++) rq.crd[c] = cv;
      rq.knot = KNOT_W'(knot);
      rq.u    = KNOT_W'(u);
      return rq;
   endfunction

   function curve_req_type rand_req(logic [1:0] kind, int idx);
      curve_req_type rq;
      rq.kind = kind;
      rq.idx  = IDX_W'(idx);
      for (int c = 0; c < 4; c++) rq.crd[c] = pick_coord();
      rq.knot = KNOT_W'($urandom_range(0, 131071));
      rq.u    = KNOT_W'($urandom_range(0, 131071));
      return rq;
   endfunction

   function bit all_loaded();
      for (int i = 0; i <= cur_last; i++) if (!written[i]) return 0;
      return 1;
   endfunction

   // Points 0..n with rising parameters, now and then a repeated one
   task automatic load_curve();
      curve_req_type rq;
      int            k;
      k = $urandom_range(0, 4000);
      for (int i = 0; i <= cur_last; i++) begin
         rq = rand_req(REQ_LOAD, i);
         rq.knot = KNOT_W'((k > 131071) ? 131071 : k);
         send(rq);
         if ($urandom_range(0, 99) >= 4)
            k += $urandom_range(1, 2 * 65536 / (cur_last + 1));
      end
   endtask

   task automatic run_random();
      curve_req_type rq;
      int            r, ops, j;
      while (sent < 1300) begin
         r = $urandom_range(0, 99);
         if (r < 55)      write_last(IDX_W'($urandom_range(2, 6)));
         else if (r < 75) write_last(IDX_W'($urandom_range(7, 20)));
         else if (r < 85) write_last(IDX_W'(63));
         else             write_last(IDX_W'($urandom_range(0, 63)));
         no_gaps = ($urandom_range(0, 3) == 0);
         if (!all_loaded() || $urandom_range(0, 4) != 0) load_curve();
         ops = $urandom_range(8, 24);
         for (int k = 0; k < ops; k++) begin
            r = $urandom_range(0, 99);
            j = $urandom_range(0, cur_last);
            if (r < 50) begin
               rq = rand_req(REQ_EVAL, 0);
               rq.u = (gen_knot[cur_last] > gen_knot[0]) ?
                      KNOT_W'($urandom_range(gen_knot[0], gen_knot[cur_last])) :
                      gen_knot[0];
            end else if (r < 60) begin
               rq = rand_req(REQ_EVAL, 0);
               rq.u = gen_knot[j];
            end else if (r < 70) begin
               rq = rand_req(REQ_EVAL, 0);
            end else if (r < 85) begin
               j = $urandom_range(0, 63);
               while (!written[j]) j = $urandom_range(0, 63);
               rq = rand_req(REQ_EDIT, j);
            end else if (r < 95) begin
               rq = rand_req(REQ_LOAD, $urandom_range(0, 63));
            end else begin
               rq = rand_req(REQ_SPARE, $urandom_range(0, 63));
            end
            send(rq);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: clamped register, extremes, saturation, equal parameters
      write_last(IDX_W'(0));
      send(mk(REQ_LOAD, 0, 32'sh7FFFFFFF, 0, 0));
      send(mk(REQ_LOAD, 1, 32'sh80000000, 32768, 0));
      send(mk(REQ_LOAD, 2, 32'sh0, 65536, 0));
      send(mk(REQ_EVAL, 0, 0, 0, 0));
      send(mk(REQ_EVAL, 0, 0, 0, 65536));
      send(mk(REQ_EVAL, 0, 0, 0, 32768));
      send(mk(REQ_EVAL, 0, 0, 0, 131071));
      send(mk(REQ_EVAL, 0, 0, 0, 16384));
      send(mk(REQ_SPARE, 63, -32'sh1, 131071, 131071));
      send(mk(REQ_EDIT, 0, 32'sh7FFFFFFF, 0, 0));
      send(mk(REQ_EDIT, 1, -32'sh1, 0, 0));
      send(mk(REQ_LOAD, 0, 32'sh10000, 0, 0));
      send(mk(REQ_LOAD, 1, 32'sh20000, 32768, 0));
      send(mk(REQ_LOAD, 2, -32'sh10000, 65536, 0));
      send(mk(REQ_EVAL, 0, 0, 0, 20000));
      send(mk(REQ_LOAD, 1, 32'sh20000, 0, 0));
      send(mk(REQ_EVAL, 0, 0, 0, 0));
      send(mk(REQ_LOAD, 63, 32'sh80000000, 131071, 0));
      write_last(IDX_W'(1));
      send(mk(REQ_LOAD, 1, 32'sh30000, 40000, 0));
      send(mk(REQ_EVAL, 0, 0, 0, 40000));
      run_random();
      wait_drained();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
